// ----- hw/rtl/mts_pkg.sv -----
// shared types, codes and widths for the minimum tracking stack
// no dependencies
`timescale 1ns / 1ps

package mts_pkg;

    localparam int STACK_DEPTH_DEF = 1024;
    localparam int DATA_W          = 32;
    localparam int COUNT_FIELD_W   = 11;
    localparam int IN_TDATA_W      = 40;
    localparam int OUT_TDATA_W     = 80;

    localparam logic [1:0] ACT_PUSH = 2'd0;
    localparam logic [1:0] ACT_POP  = 2'd1;
    localparam logic [1:0] ACT_READ = 2'd2;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_OVERFLOW  = 2'd1,
        STAT_UNDERFLOW = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_POP
    } t_state;

endpackage

// ----- hw/rtl/mts_ram.sv -----
// single write port, single read port synchronous memory, registered read
// depends on nothing but its parameters
`timescale 1ns / 1ps

module mts_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 32
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/min_tracking_stack_top.sv -----
// minimum tracking stack: value stack plus auxiliary stack of minima in two memories
// uses mts_pkg and mts_ram
// push, read and refused words: result word registered on acceptance
// pop: S_IDLE then S_POP, the new tops come back through the registered memory read
// push and read: one word per cycle while results are taken; S_POP takes no word
// synchronous active-low reset empties both stacks; memory contents are kept
`timescale 1ns / 1ps

module min_tracking_stack_top #(
    parameter int STACK_DEPTH = mts_pkg::STACK_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // action [1:0], value [33:2], zero [39:34]
    input  logic [mts_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // top_value [31:0], min_value [63:32], is_empty [64], entry_count [75:65],
    // status [77:76], zero [79:78]
    output logic [mts_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    import mts_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);
    localparam logic [CW-1:0] ONE  = CW'(1);
    localparam logic [CW-1:0] TWO  = CW'(2);

    t_state                  r_state, n_state;
    logic [CW-1:0]           r_vc, n_vc;
    logic [CW-1:0]           r_mc, n_mc;
    logic [DATA_W-1:0]       r_top, n_top;
    logic [DATA_W-1:0]       r_min, n_min;
    logic                    r_pop_min, n_pop_min;
    logic                    r_ov;
    logic [OUT_TDATA_W-1:0]  r_odata;

    logic                    w_accept;
    logic                    w_out_free;
    logic                    w_load_out;
    t_status                 w_status;
    logic [1:0]              w_action;
    logic [DATA_W-1:0]       w_value;
    logic                    w_v_we, w_m_we, w_rd_en;
    logic [CW-1:0]           w_v_raddr_full, w_m_raddr_full;
    logic [DATA_W-1:0]       w_v_rdata, w_m_rdata;
    logic [CW+COUNT_FIELD_W-1:0] w_cnt_ext;
    logic                    w_empty;
    logic [DATA_W-1:0]       w_out_top, w_out_min;
    logic [OUT_TDATA_W-1:0]  w_out_data;

    assign w_action   = s_axis_tdata[1:0];
    assign w_value    = s_axis_tdata[DATA_W+1:2];
    assign w_out_free = !r_ov || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && w_out_free;
    assign w_accept   = s_axis_tvalid && s_axis_tready;

    assign w_v_raddr_full = r_vc - TWO;
    assign w_m_raddr_full = r_mc - TWO;

    mts_ram #(.DEPTH(STACK_DEPTH), .AW(AW), .DW(DATA_W)) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (w_v_we),
        .i_waddr (r_vc[AW-1:0]),
        .i_wdata (w_value),
        .i_re    (w_rd_en),
        .i_raddr (w_v_raddr_full[AW-1:0]),
        .o_rdata (w_v_rdata)
    );

    mts_ram #(.DEPTH(STACK_DEPTH), .AW(AW), .DW(DATA_W)) u_min_ram (
        .i_clk   (i_clk),
        .i_we    (w_m_we),
        .i_waddr (r_mc[AW-1:0]),
        .i_wdata (w_value),
        .i_re    (w_rd_en),
        .i_raddr (w_m_raddr_full[AW-1:0]),
        .o_rdata (w_m_rdata)
    );

    always_comb begin
        n_state    = r_state;
        n_vc       = r_vc;
        n_mc       = r_mc;
        n_top      = r_top;
        n_min      = r_min;
        n_pop_min  = r_pop_min;
        w_v_we     = 1'b0;
        w_m_we     = 1'b0;
        w_rd_en    = 1'b0;
        w_load_out = 1'b0;
        w_status   = STAT_OK;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (w_action)
                        ACT_PUSH: begin
                            w_load_out = 1'b1;
                            if (r_vc == FULL) begin
                                w_status = STAT_OVERFLOW;
                            end else begin
                                w_v_we = 1'b1;
                                n_vc   = r_vc + ONE;
                                n_top  = w_value;
                                if ((r_mc == '0 || $signed(w_value) <= $signed(r_min))
                                        && r_mc != FULL) begin
                                    w_m_we = 1'b1;
                                    n_mc   = r_mc + ONE;
                                    n_min  = w_value;
                                end
                            end
                        end
                        ACT_POP: begin
                            if (r_vc == '0) begin
                                w_load_out = 1'b1;
                                w_status   = STAT_UNDERFLOW;
                            end else begin
                                n_vc      = r_vc - ONE;
                                n_pop_min = (r_mc != '0) && (r_top == r_min);
                                if (n_pop_min) begin
                                    n_mc = r_mc - ONE;
                                end
                                w_rd_en = 1'b1;
                                n_state = S_POP;
                            end
                        end
                        default: begin
                            w_load_out = 1'b1;
                        end
                    endcase
                end
            end
            S_POP: begin
                if (w_out_free) begin
                    n_top = w_v_rdata;
                    if (r_pop_min) begin
                        n_min = w_m_rdata;
                    end
                    w_load_out = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign w_cnt_ext  = {{COUNT_FIELD_W{1'b0}}, n_vc};
    assign w_empty    = (n_vc == '0);
    assign w_out_top  = w_empty ? '0 : n_top;
    assign w_out_min  = (w_empty || n_mc == '0) ? '0 : n_min;
    assign w_out_data = {2'b00, w_status, w_cnt_ext[COUNT_FIELD_W-1:0], w_empty,
                         w_out_min, w_out_top};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_vc      <= '0;
            r_mc      <= '0;
            r_pop_min <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_vc      <= n_vc;
            r_mc      <= n_mc;
            r_pop_min <= n_pop_min;
            if (w_load_out) begin
                r_ov <= 1'b1;
            end else if (m_axis_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_top <= n_top;
        r_min <= n_min;
        if (w_load_out) begin
            r_odata <= w_out_data;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_odata;

endmodule

// ----- hw/rtl/min_tracking_stack_chk.sv -----
// port-level checks for the minimum tracking stack, bound to the top level
// uses mts_pkg; attached to min_tracking_stack_top by the bind below
`timescale 1ns / 1ps

module min_tracking_stack_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [mts_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [mts_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    import mts_pkg::*;

    logic          w_empty;
    logic [10:0]   w_count;
    logic [1:0]    w_status;

    assign w_empty   = m_axis_tdata[64];
    assign w_count   = m_axis_tdata[75:65];
    assign w_status  = m_axis_tdata[77:76];

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (w_count != '0) |-> !w_empty)
        else $error("empty flag set with entries held");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && w_empty |-> (m_axis_tdata[63:0] == '0))
        else $error("top or minimum not zero on empty stack");

    a_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (w_status == STAT_UNDERFLOW) |-> w_empty && (w_count == '0))
        else $error("underflow reported on non-empty stack");

    a_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (w_status == STAT_OVERFLOW) |-> !w_empty)
        else $error("overflow reported on empty stack");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

endmodule

bind min_tracking_stack_top min_tracking_stack_chk u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ----- tb/min_tracking_stack_top_tb.sv -----
// testbench for min_tracking_stack_top: directed and random push, pop and read words
// checked against an in-bench shadow of both stacks; depends on mts_pkg and the rtl
`timescale 1ns / 1ps

module min_tracking_stack_top_tb;

    import mts_pkg::*;

    localparam int          DEPTH      = STACK_DEPTH_DEF;
    localparam logic [1:0]  ACT_SPARE  = 2'd3;
    localparam int          RANDOM_OPS = 200;
    localparam int          FULL_POPS  = 32;

    typedef struct packed {
        logic signed [31:0] top;
        logic signed [31:0] minimum;
        logic               empty;
        logic [10:0]        count;
        t_status            status;
    } t_stack_view;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // action [1:0], value [33:2], zero [39:34]
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // top_value [31:0], min_value [63:32], is_empty [64], entry_count [75:65],
    // status [77:76], zero [79:78]
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    logic [31:0]  shadow_values [DEPTH];
    logic [31:0]  shadow_minima [DEPTH];
    int           shadow_count;
    int           shadow_min_count;
    t_stack_view  expected_views [$];

    int burst_left;
    int mismatches;
    int words_checked;
    int pushes_sent;
    int pops_sent;
    int reads_sent;
    int overflows_seen;
    int underflows_seen;

    min_tracking_stack_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("timeout with %0d words outstanding", expected_views.size());
        $display("[min_tracking_stack_top] ERROR");
        $finish;
    end

    // shadow of both stacks, updated once per accepted word
    function automatic t_stack_view apply_stack_op(input logic [1:0] act,
                                                   input logic [31:0] val);
        t_stack_view view;
        logic [31:0] gone;
        view.status = STAT_OK;
        if (act == ACT_PUSH) begin
            if (shadow_count >= DEPTH) begin
                view.status = STAT_OVERFLOW;
            end else begin
                shadow_values[shadow_count] = val;
                shadow_count++;
                if (shadow_min_count == 0 ||
                    $signed(val) <= $signed(shadow_minima[shadow_min_count-1])) begin
                    if (shadow_min_count < DEPTH) begin
                        shadow_minima[shadow_min_count] = val;
                        shadow_min_count++;
                    end
                end
            end
        end else if (act == ACT_POP) begin
            if (shadow_count == 0) begin
                view.status = STAT_UNDERFLOW;
            end else begin
                shadow_count--;
                gone = shadow_values[shadow_count];
                if (shadow_min_count > 0 && gone == shadow_minima[shadow_min_count-1])
                    shadow_min_count--;
            end
        end
        view.top     = (shadow_count > 0) ? shadow_values[shadow_count-1] : '0;
        view.minimum = (shadow_count > 0 && shadow_min_count > 0) ?
                       shadow_minima[shadow_min_count-1] : '0;
        view.empty   = (shadow_count == 0);
        view.count   = shadow_count[10:0];
        return view;
    endfunction

    // mix of a small pool for repeats and equal minima, extremes and full-range values
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2: return 32'($urandom_range(0, 15)) - 32'd8;
            3: begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7fff_ffff;
                    2: return 32'hffff_ffff;
                    default: return 32'h0000_0000;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    // called and returns at a falling edge; bursts of words separated by random gaps
    task automatic send_word(input logic [1:0] act, input logic [31:0] val);
        int gap;
        t_stack_view view;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) :
                                                       $urandom_range(1, 12);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, val, act};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        view = apply_stack_op(act, val);
        expected_views.push_back(view);
        case (act)
            ACT_PUSH: pushes_sent++;
            ACT_POP:  pops_sent++;
            default:  reads_sent++;
        endcase
        if (view.status == STAT_OVERFLOW)  overflows_seen++;
        if (view.status == STAT_UNDERFLOW) underflows_seen++;
        burst_left--;
        @(negedge i_clk);
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("%0t mismatch on word %0d: %s expected 0x%08h got 0x%08h",
                 $realtime, words_checked, field, want, got);
        mismatches++;
    endtask

    // receiver stall pattern: free-running, random, or mostly stalled stretches
    initial begin
        int mode;
        int span;
        forever begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(10, 60);
            repeat (span) begin
                @(negedge i_clk);
                case (mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= $urandom_range(0, 1);
                    default: m_axis_tready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        t_stack_view want;
        t_stack_view got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.top     = m_axis_tdata[31:0];
            got.minimum = m_axis_tdata[63:32];
            got.empty   = m_axis_tdata[64];
            got.count   = m_axis_tdata[75:65];
            got.status  = t_status'(m_axis_tdata[77:76]);
            if (expected_views.size() == 0) begin
                report_mismatch("unexpected word", '0, got.top);
            end else begin
                want = expected_views.pop_front();
                if (got.top !== want.top)
                    report_mismatch("top_value", want.top, got.top);
                if (got.minimum !== want.minimum)
                    report_mismatch("min_value", want.minimum, got.minimum);
                if (got.empty !== want.empty)
                    report_mismatch("is_empty", 32'(want.empty), 32'(got.empty));
                if (got.count !== want.count)
                    report_mismatch("entry_count", 32'(want.count), 32'(got.count));
                if (got.status !== want.status)
                    report_mismatch("status", 32'(want.status), 32'(got.status));
            end
            words_checked++;
        end
    end

    task automatic test_empty_stack();
        send_word(ACT_READ, 32'h1234_5678);
        send_word(ACT_POP, 32'hffff_ffff);
        send_word(ACT_SPARE, 32'h0);
        send_word(ACT_POP, 32'h8000_0000);
    endtask

    // extremes, equal minima pushed twice, unused action code, drain past empty
    task automatic test_extremes_and_duplicates();
        send_word(ACT_PUSH, 32'h7fff_ffff);
        send_word(ACT_PUSH, 32'h0000_0000);
        send_word(ACT_PUSH, 32'h8000_0000);
        send_word(ACT_PUSH, 32'h8000_0000);
        send_word(ACT_PUSH, 32'hffff_ffff);
        send_word(ACT_PUSH, 32'haaaa_aaaa);
        send_word(ACT_PUSH, 32'h5555_5555);
        send_word(ACT_READ, 32'hffff_ffff);
        send_word(ACT_SPARE, 32'h5555_5555);
        repeat (4) send_word(ACT_POP, 32'haaaa_aaaa);
        send_word(ACT_READ, 32'h0);
        repeat (4) send_word(ACT_POP, 32'h0);
    endtask

    // fill to the last entry, refuse pushes while full, then pop back a short stretch
    task automatic test_full_stack();
        while (shadow_count < DEPTH) begin
            if ($urandom_range(0, 15) == 0)
                send_word(ACT_READ, $urandom);
            else
                send_word(ACT_PUSH, pick_value());
        end
        repeat (3) send_word(ACT_PUSH, pick_value());
        send_word(ACT_SPARE, $urandom);
        repeat (FULL_POPS) send_word(ACT_POP, $urandom);
    endtask

    // random walk with a push bias that changes between phases
    task automatic test_random_walk();
        int push_pct;
        int roll;
        for (int n = 0; n < RANDOM_OPS; n++) begin
            if (n % 64 == 0) begin
                case ($urandom_range(0, 3))
                    0:       push_pct = 20;
                    1:       push_pct = 50;
                    2:       push_pct = 75;
                    default: push_pct = 95;
                endcase
            end
            roll = $urandom_range(0, 99);
            if (roll < push_pct)
                send_word(ACT_PUSH, pick_value());
            else if (roll % 8 == 0)
                send_word(($urandom_range(0, 1) != 0) ? ACT_READ : ACT_SPARE, $urandom);
            else
                send_word(ACT_POP, $urandom);
        end
    endtask

    initial begin
        shadow_count     = 0;
        shadow_min_count = 0;
        burst_left       = 0;
        mismatches       = 0;
        words_checked    = 0;
        pushes_sent      = 0;
        pops_sent        = 0;
        reads_sent       = 0;
        overflows_seen   = 0;
        underflows_seen  = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_empty_stack();
        test_extremes_and_duplicates();
        test_full_stack();
        test_random_walk();

        s_axis_tvalid <= 1'b0;
        while (expected_views.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("%0d words checked: %0d pushes, %0d pops, %0d reads", words_checked,
                 pushes_sent, pops_sent, reads_sent);
        $display("%0d refused pushes on a full stack, %0d refused pops on an empty one",
                 overflows_seen, underflows_seen);
        if (mismatches == 0) begin
            $display("[min_tracking_stack_top] OK");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("[min_tracking_stack_top] ERROR");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/mts_pkg.sv
hw/rtl/mts_ram.sv
hw/rtl/min_tracking_stack_top.sv
hw/rtl/min_tracking_stack_chk.sv
tb/min_tracking_stack_top_tb.sv
